// ===== rtl/shae_pkg.sv =====
`default_nettype none

package shae_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned WinDepth = 16;

  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [2:0] LenRow = 3'b111;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [5:0] FillLast = 6'd63;
  localparam logic [2:0] Sha256Last = 3'd7;
  localparam logic [2:0] Sha224Last = 3'd6;

  localparam logic [WordW-1:0] Iv256 [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] Iv224 [NumWords] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic       absorb;
    logic       finish;
    logic       round;
    logic       update;
    logic       len_block;
    logic       restart;
    logic       cfg_write;
    logic [5:0] round_idx;
    logic [2:0] word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic needs_extra;
    logic mode_sha224;
  } dp_status_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_sha224_hash_engine_unit.sv =====
// SHA-256 / SHA-224 hasher. Each input word carries one message byte (tuser low) or a
// finish request (tuser high); after a finish the digest leaves as eight words for
// SHA-256 or seven for SHA-224, word 0 first, and a new message starts. The byte that
// completes a 64-byte block starts 64 rounds of the single round unit plus one chain
// update, and no input is taken meanwhile. A finish pads and hashes the last block
// and an extra length block when the length needs it, before the digest words appear at
// up to one per cycle while the receiver is ready. A mode write is taken only while the
// engine is idle, has priority over an input word, and also restarts the message.
`default_nettype none

module sha256_sha224_hash_engine_unit import shae_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  shae_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_command_i (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_last_o   (m_axis_tlast),
    .out_index_o  (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  shae_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata),
    .cfg_data_i    (cfg_data_i),
    .status_o      (status),
    .digest_word_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/shae_datapath.sv =====
`default_nettype none

module shae_datapath import shae_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             cfg_data_i,
  output dp_status_t            status_o,
  output logic [WordW-1:0]      digest_word_o
);

  logic             mode_q, mode_d;
  logic [63:0]      bits_q, bits_d;
  logic [WordW-1:0] chain_q [NumWords];
  logic [WordW-1:0] chain_d [NumWords];
  logic [WordW-1:0] vars_q [NumWords];
  logic [WordW-1:0] vars_d [NumWords];
  logic [WordW-1:0] win_q [WinDepth];
  logic [WordW-1:0] win_d [WinDepth];

  logic [5:0]       fill;
  logic             needs_extra;
  logic [WordW-1:0] t1, t2, w_new, ch, maj;

  assign fill        = bits_q[8:3];
  assign needs_extra = (fill[5:3] == LenRow);

  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + big_sigma1(vars_q[4]) + ch + RoundK[cmd_i.round_idx] + win_q[0];
  assign t2  = big_sigma0(vars_q[0]) + maj;
  assign w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

  always_comb begin
    logic [5:0] pos;
    pos = '0;
    win_d = win_q;
    if (cmd_i.absorb) begin
      win_d[fill[5:2]][{~fill[1:0], 3'b000} +: 8] = data_byte_i;
    end else if (cmd_i.finish) begin
      for (int i = 0; i < WinDepth; i++) begin
        for (int j = 0; j < 4; j++) begin
          pos = 6'(i * 4 + j);
          if (pos == fill) begin
            win_d[i][(3 - j) * 8 +: 8] = PadByte;
          end else if (pos > fill) begin
            win_d[i][(3 - j) * 8 +: 8] = 8'h00;
          end
        end
      end
      if (!needs_extra) begin
        win_d[WinDepth-2] = bits_q[63:32];
        win_d[WinDepth-1] = bits_q[31:0];
      end
    end else if (cmd_i.round) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[WinDepth-1] = w_new;
    end else if (cmd_i.len_block) begin
      for (int i = 0; i < WinDepth - 2; i++) begin
        win_d[i] = '0;
      end
      win_d[WinDepth-2] = bits_q[63:32];
      win_d[WinDepth-1] = bits_q[31:0];
    end
  end

  always_comb begin
    mode_d  = mode_q;
    bits_d  = bits_q;
    chain_d = chain_q;
    vars_d  = vars_q;
    if (cmd_i.cfg_write || cmd_i.restart) begin
      if (cmd_i.cfg_write) begin
        mode_d = cfg_data_i;
      end
      bits_d = '0;
      for (int i = 0; i < NumWords; i++) begin
        chain_d[i] = mode_d ? Iv224[i] : Iv256[i];
        vars_d[i]  = mode_d ? Iv224[i] : Iv256[i];
      end
    end else if (cmd_i.absorb) begin
      bits_d = bits_q + 64'd8;
    end else if (cmd_i.round) begin
      for (int i = 1; i < NumWords; i++) begin
        vars_d[i] = vars_q[i-1];
      end
      vars_d[4] = vars_q[3] + t1;
      vars_d[0] = t1 + t2;
    end else if (cmd_i.update) begin
      for (int i = 0; i < NumWords; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
        vars_d[i]  = chain_q[i] + vars_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      bits_q <= '0;
      for (int i = 0; i < NumWords; i++) begin
        chain_q[i] <= Iv256[i];
        vars_q[i]  <= Iv256[i];
      end
    end else begin
      mode_q  <= mode_d;
      bits_q  <= bits_d;
      chain_q <= chain_d;
      vars_q  <= vars_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign status_o.fill_last   = (fill == FillLast);
  assign status_o.needs_extra = needs_extra;
  assign status_o.mode_sha224 = mode_q;
  assign digest_word_o        = chain_q[cmd_i.word_idx];

endmodule

`default_nettype wire

// ===== rtl/shae_ctrl.sv =====
`default_nettype none

module shae_ctrl import shae_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       in_command_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            out_last_o,
  output logic [2:0]      out_index_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  word_q, word_d;
  logic        final_q, final_d;
  logic        extra_q, extra_d;
  logic        in_acc, out_acc, is_last;

  assign in_acc  = in_valid_i && (state_q == ST_IDLE) && !cfg_valid_i;
  assign out_acc = out_ready_i && (state_q == ST_OUT);
  assign is_last = (word_q == (status_i.mode_sha224 ? Sha224Last : Sha256Last));

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    word_d  = word_q;
    final_d = final_q;
    extra_d = extra_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command_i == CmdFinish) begin
            state_d = ST_ROUND;
            final_d = 1'b1;
            extra_d = status_i.needs_extra;
          end else if (status_i.fill_last) begin
            state_d = ST_ROUND;
            final_d = 1'b0;
            extra_d = 1'b0;
          end
        end
      end
      ST_ROUND: begin
        round_d = round_q + 6'd1;
        if (round_q == RoundLast) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (extra_q) begin
          extra_d = 1'b0;
          state_d = ST_ROUND;
        end else if (final_q) begin
          final_d = 1'b0;
          word_d  = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (is_last) begin
            word_d  = '0;
            state_d = ST_IDLE;
          end else begin
            word_d = word_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
    out_valid_o = (state_q == ST_OUT);
    out_last_o  = is_last;
    out_index_o = word_q;
    cfg_ready_o = (state_q == ST_IDLE);
    cmd_o.absorb    = in_acc && (in_command_i == CmdAbsorb);
    cmd_o.finish    = in_acc && (in_command_i == CmdFinish);
    cmd_o.round     = (state_q == ST_ROUND);
    cmd_o.update    = (state_q == ST_UPDATE);
    cmd_o.len_block = (state_q == ST_UPDATE) && extra_q;
    cmd_o.restart   = out_acc && is_last;
    cmd_o.cfg_write = cfg_valid_i && (state_q == ST_IDLE);
    cmd_o.round_idx = round_q;
    cmd_o.word_idx  = word_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      word_q  <= '0;
      final_q <= 1'b0;
      extra_q <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      word_q  <= word_d;
      final_q <= final_d;
      extra_q <= extra_d;
    end
  end

  a_extra_needs_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    extra_q |-> final_q)
    else $error("extra padding block pending without a finish");

  a_round_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && round_q == RoundLast) |=> (state_q == ST_UPDATE))
    else $error("last round not followed by chain update");

  a_idle_round_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (round_q == 6'd0))
    else $error("round counter not cleared between blocks");

  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while digest words are pending");

endmodule

`default_nettype wire
